>>> hdl/fbd_pkg.sv
// ----------------------------------------------------------------------------
// fbd_pkg: shared types and constants of the front/back deque
// Command codes and the data width of one stored entry.
// ----------------------------------------------------------------------------
package fbd_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;

    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // Command codes; the spare code lists the contents unchanged.
    localparam cmd_t CMD_POP_FRONT  = 2'd0;
    localparam cmd_t CMD_ENQ_BACK   = 2'd1;
    localparam cmd_t CMD_PUSH_FRONT = 2'd2;
    localparam cmd_t CMD_NOP        = 2'd3;

endpackage

>>> hdl/fbd_ram.sv
// ----------------------------------------------------------------------------
// fbd_ram: generic single-write, single-read synchronous RAM
// Registered read; the read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module fbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/front_back_deque.sv
// ----------------------------------------------------------------------------
// front_back_deque: bounded double-ended queue of signed 32-bit values
// Ring store in a synchronous RAM with front pointer and entry count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, command, value) takes one command per
//   transfer: pop front, enqueue at back, push at front, or no operation;
//   the store is updated in the transfer cycle itself.
//   Output channel (out_valid/out_ready) then lists the whole contents front
//   to back, one transfer per entry, last_mark on the final one. An empty
//   deque gives one transfer with empty_mark and last_mark set and a zero
//   entry_value. An insert into a full store is dropped and dropped_mark is
//   set on every transfer of that listing.
//   Rate: the single RAM read port walks the ring one entry per cycle while
//   the receiver keeps up; a listing has max(1, N) transfers, N being the
//   entry count after the command (at most DEPTH = 32).
//   After a command transfer the walk starts (list_active), then its first
//   step reads the RAM into the output register and raises out_valid.
//   in_ready is high whenever no listing is still being issued; the last
//   result may still wait in the output register while a new command is taken.
//   A stalled receiver freezes the walk: the RAM read data is the output
//   register and holds until taken.
//   Reset empties the deque (front pointer and count to zero); the RAM
//   contents are not cleared, since only written entries are ever listed.
// ----------------------------------------------------------------------------
module front_back_deque #(
    parameter int DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbd_pkg::cmd_t       command,
    input  fbd_pkg::data_t      value,
    output logic                out_valid,
    input  logic                out_ready,
    output fbd_pkg::data_t      entry_value,
    output logic                empty_mark,
    output logic                last_mark,
    output logic                dropped_mark
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

    // Deque state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Listing walk
    logic             list_active_reg, list_active_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    // Drop flag of the command being listed, copied into each result
    logic             drop_cmd_reg, drop_cmd_next;

    // Output register flags (data comes from the RAM read register)
    logic             out_valid_reg, out_valid_next;
    logic             empty_reg, empty_next;
    logic             last_reg, last_next;
    logic             drop_reg, drop_next;

    logic             accept;
    logic             issue;
    logic             is_full;
    logic             is_empty;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] rd_ptr_inc;
    logic [SUM_W-1:0] back_sum;
    logic [IDX_W-1:0] back_idx;

    logic                     ram_wr_en;
    logic [IDX_W-1:0]         ram_wr_addr;
    logic                     ram_rd_en;
    logic [fbd_pkg::DATA_W-1:0] ram_rd_data;

    assign in_ready = !list_active_reg;
    assign accept   = in_valid && in_ready;
    // Issue the next listing step when the output register is free or drains
    assign issue    = list_active_reg && (!out_valid_reg || out_ready);

    assign is_full  = (count_reg == CNT_FULL);
    assign is_empty = (count_reg == '0);

    assign front_inc  = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec  = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == IDX_LAST) ? '0 : rd_ptr_reg + 1'b1;

    // Back slot: front + count, wrapped once (both below DEPTH when not full)
    assign back_sum = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_idx = (back_sum >= SUM_DEPTH) ? IDX_W'(back_sum - SUM_DEPTH)
                                              : IDX_W'(back_sum);

    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        list_active_next = list_active_reg;
        rd_ptr_next      = rd_ptr_reg;
        rem_next         = rem_reg;
        drop_cmd_next    = drop_cmd_reg;
        out_valid_next   = out_valid_reg;
        empty_next       = empty_reg;
        last_next        = last_reg;
        drop_next        = drop_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = back_idx;
        ram_rd_en        = 1'b0;

        // Drop the result once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            drop_cmd_next = 1'b0;
            unique case (command)
                fbd_pkg::CMD_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                fbd_pkg::CMD_ENQ_BACK:
                begin
                    if (is_full)
                    begin
                        drop_cmd_next = 1'b1;
                    end
                    else
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = back_idx;
                        count_next  = count_reg + 1'b1;
                    end
                end
                fbd_pkg::CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        drop_cmd_next = 1'b1;
                    end
                    else
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = front_dec;
                        front_next  = front_dec;
                        count_next  = count_reg + 1'b1;
                    end
                end
                fbd_pkg::CMD_NOP:
                begin
                    // hold the contents; listing only
                end
                default:
                begin
                end
            endcase
            // Start the walk at the updated front
            list_active_next = 1'b1;
            rd_ptr_next      = front_next;
            rem_next         = count_next;
        end
        else if (issue)
        begin
            out_valid_next = 1'b1;
            drop_next      = drop_cmd_reg;
            if (rem_reg == '0)
            begin
                // Empty deque: single marked result
                empty_next       = 1'b1;
                last_next        = 1'b1;
                list_active_next = 1'b0;
            end
            else
            begin
                ram_rd_en   = 1'b1;
                empty_next  = 1'b0;
                last_next   = (rem_reg == CNT_W'(1));
                rd_ptr_next = rd_ptr_inc;
                rem_next    = rem_reg - 1'b1;
                if (rem_reg == CNT_W'(1))
                begin
                    list_active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg       <= '0;
            count_reg       <= '0;
            list_active_reg <= 1'b0;
            rd_ptr_reg      <= '0;
            rem_reg         <= '0;
            drop_cmd_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            empty_reg       <= 1'b0;
            last_reg        <= 1'b0;
            drop_reg        <= 1'b0;
        end
        else
        begin
            front_reg       <= front_next;
            count_reg       <= count_next;
            list_active_reg <= list_active_next;
            rd_ptr_reg      <= rd_ptr_next;
            rem_reg         <= rem_next;
            drop_cmd_reg    <= drop_cmd_next;
            out_valid_reg   <= out_valid_next;
            empty_reg       <= empty_next;
            last_reg        <= last_next;
            drop_reg        <= drop_next;
        end
    end

    fbd_ram #(
        .WIDTH (fbd_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (value),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign out_valid    = out_valid_reg;
    assign entry_value  = empty_reg ? '0 : fbd_pkg::data_t'(ram_rd_data);
    assign empty_mark   = empty_reg;
    assign last_mark    = last_reg;
    assign dropped_mark = drop_reg;

`ifndef SYNTH
    // Count never exceeds the ring depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above depth");

    // Front pointer stays inside the ring
    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= IDX_LAST)
        else $error("front pointer out of range");

    // An empty listing is always a single, final result
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && empty_reg |-> last_reg)
        else $error("empty result not marked last");

    // A command transfer starts a listing walk
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> list_active_reg && rem_reg == $past(count_next))
        else $error("listing not started after command");
`endif

endmodule

>>> sim/front_back_deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_back_deque_checker: listing predictor and scoreboard
// Tracks every command transfer, keeps its own copy of the deque, and
// compares each listing transfer field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module front_back_deque_checker #(
    parameter int DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  fbd_pkg::cmd_t  command,
    input  fbd_pkg::data_t value,
    input  logic           out_valid,
    input  logic           out_ready,
    input  fbd_pkg::data_t entry_value,
    input  logic           empty_mark,
    input  logic           last_mark,
    input  logic           dropped_mark,
    output int             error_count,
    output int             pending_count,
    output int             cmd_count,
    output int             result_count,
    output int             drop_count,
    output int             empty_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        fbd_pkg::data_t entry_v;
        logic           empty_v;
        logic           last_v;
        logic           dropped_v;
    } listing_t;

    fbd_pkg::data_t   ring [DEPTH];
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] held;
    listing_t         listing_q [$];
    int               errs, cmds, results, drops, empties;

    // Apply one command to the shadow deque and queue up its listing.
    task automatic update_and_list(input fbd_pkg::cmd_t cmd, input fbd_pkg::data_t val);
        logic     dropped;
        int       h;
        int       n;
        listing_t item;
        dropped = 1'b0;
        h = int'(head);
        n = int'(held);
        case (cmd)
            fbd_pkg::CMD_POP_FRONT:
            begin
                if (n > 0)
                begin
                    h = (h + 1) % DEPTH;
                    n = n - 1;
                end
            end
            fbd_pkg::CMD_ENQ_BACK:
            begin
                if (n >= DEPTH)
                    dropped = 1'b1;
                else
                begin
                    ring[(h + n) % DEPTH] = val;
                    n = n + 1;
                end
            end
            fbd_pkg::CMD_PUSH_FRONT:
            begin
                if (n >= DEPTH)
                    dropped = 1'b1;
                else
                begin
                    h = (h + DEPTH - 1) % DEPTH;
                    ring[h] = val;
                    n = n + 1;
                end
            end
            default:
            begin
            end
        endcase
        head = h[IDX_W-1:0];
        held = n[CNT_W-1:0];

        if (n == 0)
        begin
            item.entry_v   = '0;
            item.empty_v   = 1'b1;
            item.last_v    = 1'b1;
            item.dropped_v = dropped;
            listing_q.push_back(item);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                item.entry_v   = ring[(h + i) % DEPTH];
                item.empty_v   = 1'b0;
                item.last_v    = (i == n - 1);
                item.dropped_v = dropped;
                listing_q.push_back(item);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        listing_t want;
        if (!rst_n)
        begin
            head = '0;
            held = '0;
            listing_q.delete();
            errs    = 0;
            cmds    = 0;
            results = 0;
            drops   = 0;
            empties = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results++;
                if (dropped_mark && last_mark)
                    drops++;
                if (empty_mark)
                    empties++;
                if (listing_q.size() == 0)
                begin
                    $error("listing transfer with nothing expected: entry_value %0d",
                           entry_value);
                    errs++;
                end
                else
                begin
                    want = listing_q.pop_front();
                    if (entry_value !== want.entry_v)
                    begin
                        $error("entry_value: expected %0d, got %0d",
                               want.entry_v, entry_value);
                        errs++;
                    end
                    if (empty_mark !== want.empty_v)
                    begin
                        $error("empty_mark: expected %0b, got %0b",
                               want.empty_v, empty_mark);
                        errs++;
                    end
                    if (last_mark !== want.last_v)
                    begin
                        $error("last_mark: expected %0b, got %0b",
                               want.last_v, last_mark);
                        errs++;
                    end
                    if (dropped_mark !== want.dropped_v)
                    begin
                        $error("dropped_mark: expected %0b, got %0b",
                               want.dropped_v, dropped_mark);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                cmds++;
                update_and_list(command, value);
            end
        end
        error_count   <= errs;
        pending_count <= listing_q.size();
        cmd_count     <= cmds;
        result_count  <= results;
        drop_count    <= drops;
        empty_count   <= empties;
    end

endmodule

>>> sim/front_back_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_back_deque_tb: command stimulus and verdict for the deque
// Drives directed edge cases, then fill-to-full and drain-to-empty runs with
// random content, with random idle cycles on both channels and one long
// receiver stall; the checker beside the block scores every listing.
// ----------------------------------------------------------------------------
module front_back_deque_tb;

    localparam int DEPTH        = 32;
    localparam int HOLD_CYCLES  = 300;   // long receiver stall to back up the input
    localparam int IDLE_LIMIT   = 3000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int N_DIRECTED   = 19;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    fbd_pkg::cmd_t  command   = fbd_pkg::CMD_NOP;
    fbd_pkg::data_t value     = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    fbd_pkg::data_t entry_value;
    logic           empty_mark;
    logic           last_mark;
    logic           dropped_mark;

    int max_gap       = 4;  // upper bound of the idle cycles drawn per transfer
    int hold_requests = 0;  // bumped by the stimulus, served by the receiver
    int occupancy     = 0;  // rough fill level, used only to steer the stimulus
    int idle_cycles   = 0;

    int error_count;
    int pending_count;
    int cmd_count;
    int result_count;
    int drop_count;
    int empty_count;

    // Edge cases: pop on empty, value extremes, front wrap below slot zero,
    // spare code with a live value, pops with a nonzero value, drain to empty.
    fbd_pkg::cmd_t dir_cmd [N_DIRECTED] = '{
        fbd_pkg::CMD_POP_FRONT, fbd_pkg::CMD_ENQ_BACK, fbd_pkg::CMD_PUSH_FRONT,
        fbd_pkg::CMD_ENQ_BACK, fbd_pkg::CMD_PUSH_FRONT, fbd_pkg::CMD_NOP,
        fbd_pkg::CMD_ENQ_BACK, fbd_pkg::CMD_PUSH_FRONT, fbd_pkg::CMD_POP_FRONT,
        fbd_pkg::CMD_NOP, fbd_pkg::CMD_POP_FRONT, fbd_pkg::CMD_POP_FRONT,
        fbd_pkg::CMD_POP_FRONT, fbd_pkg::CMD_POP_FRONT, fbd_pkg::CMD_POP_FRONT,
        fbd_pkg::CMD_POP_FRONT, fbd_pkg::CMD_NOP, fbd_pkg::CMD_ENQ_BACK,
        fbd_pkg::CMD_POP_FRONT
    };
    fbd_pkg::data_t dir_val [N_DIRECTED] = '{
        32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
        32'h0F0F_0F0F, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000
    };

    always #5 clk = ~clk;

    front_back_deque #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_value (entry_value),
        .empty_mark  (empty_mark),
        .last_mark   (last_mark),
        .dropped_mark(dropped_mark)
    );

    front_back_deque_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .entry_value  (entry_value),
        .empty_mark   (empty_mark),
        .last_mark    (last_mark),
        .dropped_mark (dropped_mark),
        .error_count  (error_count),
        .pending_count(pending_count),
        .cmd_count    (cmd_count),
        .result_count (result_count),
        .drop_count   (drop_count),
        .empty_count  (empty_count)
    );

    // Watchdog: abort when neither channel has moved a transfer for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: draw a stall before each listing transfer, hold ready low for
    // it, then keep ready high until the transfer happens. A pending hold
    // request replaces the draw with one long stall.
    initial
    begin
        int stall;
        int holds_done;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, max_gap);
            if (holds_done < hold_requests)
            begin
                stall = HOLD_CYCLES;
                holds_done++;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Offer one command after a random gap and hold it until the transfer.
    task automatic send_command(input fbd_pkg::cmd_t cmd, input fbd_pkg::data_t val);
        int gap;
        gap = $urandom_range(0, max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        // Track the fill level so the phases below know when to turn around.
        if (cmd == fbd_pkg::CMD_POP_FRONT && occupancy > 0)
            occupancy--;
        else if ((cmd == fbd_pkg::CMD_ENQ_BACK || cmd == fbd_pkg::CMD_PUSH_FRONT)
                 && occupancy < DEPTH)
            occupancy++;
    endtask

    // Random command: insert_pct percent inserts, the rest mostly pops with
    // the odd spare code; values lean on the extremes now and then.
    task automatic send_random(input int insert_pct);
        fbd_pkg::cmd_t  cmd;
        fbd_pkg::data_t val;
        if ($urandom_range(0, 99) < insert_pct)
            cmd = ($urandom_range(0, 1) != 0) ? fbd_pkg::CMD_ENQ_BACK
                                              : fbd_pkg::CMD_PUSH_FRONT;
        else if ($urandom_range(0, 7) == 0)
            cmd = fbd_pkg::CMD_NOP;
        else
            cmd = fbd_pkg::CMD_POP_FRONT;
        case ($urandom_range(0, 7))
            0:       val = 32'h0000_0000;
            1:       val = 32'hFFFF_FFFF;
            2:       val = 32'h7FFF_FFFF;
            3:       val = 32'h8000_0000;
            default: val = $urandom;
        endcase
        send_command(cmd, val);
    endtask

    initial
    begin
        // Hold reset, then release it away from the clock edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_command(dir_cmd[i], dir_val[i]);

        // Fill to full; halfway up, stall the receiver long enough that the
        // block stops taking commands while the sender keeps offering.
        while (occupancy < DEPTH)
        begin
            if (occupancy == DEPTH / 2 && hold_requests == 0)
                hold_requests = 1;
            send_random(90);
        end
        // Inserts into the full store must be dropped and flagged.
        repeat (4) send_random(100);

        // Drain to empty, then poke the empty deque.
        while (occupancy > 0)
            send_random(10);
        repeat (3) send_random(0);

        // Back-to-back stretch on both channels.
        max_gap = 0;
        repeat (10) send_random(50);

        max_gap = 4;
        repeat (10) send_random(60);

        @(negedge clk);
        in_valid <= 1'b0;

        // Wait out the outstanding listings, then watch for stray transfers.
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands, %0d listing transfers, %0d dropped inserts,",
                 cmd_count, result_count, drop_count);
        $display("%0d empty listings; edge cases, fill with long stall, drain, no-gap run",
                 empty_count);
        if (error_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
